// ----- design/suv_pkg.sv -----
package suv_pkg;

    // Number formats
    localparam int CFB     = 14;          // fraction bits of the coordinates
    localparam int OFB     = 16;          // fraction bits of the texture coordinates
    localparam int COORD_W = 16;
    localparam int OUT_W   = 17;

    // Square root unit: radicand one^2 - y^2, root up to one
    localparam int SQ_IN_W = 2 * CFB + 1;
    localparam int SQ_K    = CFB + 1;
    localparam int SQ_TW   = 2 * SQ_K + 1;

    // CORDIC datapath
    localparam int CW      = 44;          // vector component width
    localparam int AW      = 35;          // angle width, 2^32 is one turn
    localparam int NIT     = 32;
    localparam int SC_XZ   = 24;
    localparam int SC_Y    = 40 - CFB;
    localparam int SIDE_W  = 3 * COORD_W;

    // Arctangent table in turns, entry i is atan(2^-i) scaled to 2^32 per turn.
    function automatic logic signed [AW-1:0] turn_tab(input logic [4:0] idx);
        logic signed [AW-1:0] t;
        case (idx)
            5'd0:    t = AW'(536870912);
            5'd1:    t = AW'(316933406);
            5'd2:    t = AW'(167458907);
            5'd3:    t = AW'(85004756);
            5'd4:    t = AW'(42667331);
            5'd5:    t = AW'(21354465);
            5'd6:    t = AW'(10679838);
            5'd7:    t = AW'(5340245);
            5'd8:    t = AW'(2670163);
            5'd9:    t = AW'(1335087);
            5'd10:   t = AW'(667544);
            5'd11:   t = AW'(333772);
            5'd12:   t = AW'(166886);
            5'd13:   t = AW'(83443);
            5'd14:   t = AW'(41722);
            5'd15:   t = AW'(20861);
            5'd16:   t = AW'(10430);
            5'd17:   t = AW'(5215);
            5'd18:   t = AW'(2608);
            5'd19:   t = AW'(1304);
            5'd20:   t = AW'(652);
            5'd21:   t = AW'(326);
            5'd22:   t = AW'(163);
            5'd23:   t = AW'(81);
            5'd24:   t = AW'(41);
            5'd25:   t = AW'(20);
            5'd26:   t = AW'(10);
            5'd27:   t = AW'(5);
            5'd28:   t = AW'(3);
            5'd29:   t = AW'(1);
            5'd30:   t = AW'(1);
            default: t = '0;
        endcase
        return t;
    endfunction

    // Clamp a turn-scaled value to 0..1 and round it to OFB fraction bits.
    function automatic logic [OUT_W-1:0] to_out(input logic signed [AW+1:0] w);
        logic signed [AW+1:0] wc;
        logic signed [AW+1:0] r;
        wc = w;
        if (wc < 0) begin
            wc = '0;
        end
        if (wc > (AW+2)'(64'sd1 <<< 32)) begin
            wc = (AW+2)'(64'sd1 <<< 32);
        end
        r = (wc + (AW+2)'(64'sd1 <<< (31 - OFB))) >>> (32 - OFB);
        if (r > (AW+2)'(64'sd1 <<< OFB)) begin
            r = (AW+2)'(64'sd1 <<< OFB);
        end
        return r[OUT_W-1:0];
    endfunction

endpackage

// ----- design/spherical_uv_mapping.sv -----
// Channel  Direction  tdata fields (lowest bit first)
// s_axis   in         x_coord[15:0], y_coord[31:16], z_coord[47:32]
// m_axis   out        tex_u[16:0], tex_v[33:17], zero pad[39:34]
//
// A vertex can enter every cycle unless the pipeline holds; the path runs through a
// register for y saturation and y^2, 15 square root stages, one CORDIC pre-rotation
// stage, 32 CORDIC iteration stages and one output rounding register.
// Reset clears all valid bits; data registers are not reset.
// When the result register is full and not taken, the whole pipeline holds.
module spherical_uv_mapping (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // x_coord, y_coord, z_coord
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // tex_u, tex_v, zero pad
);
    import suv_pkg::*;

    logic                       ce;
    logic signed [COORD_W-1:0]  x_in, y_in, z_in, y_sat;
    logic signed [31:0]         y_sq;
    logic                       r_p_vld;
    logic [SQ_IN_W-1:0]         r_p_n;
    logic [SIDE_W-1:0]          r_p_side;
    logic                       sq_vld;
    logic [SQ_K-1:0]            sq_root;
    logic [SIDE_W-1:0]          sq_side;
    logic signed [COORD_W-1:0]  sq_x, sq_y, sq_z;
    logic signed [CW-1:0]       phi_a, phi_b, th_a, th_b;
    logic                       phi_vld, th_vld;
    logic signed [AW-1:0]       phi, theta;
    logic                       r_out_vld;
    logic [OUT_W-1:0]           r_u, r_v;

    // The pipeline advances unless a result waits on a stalled consumer.
    assign ce              = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = ce;

    // Saturate y to plus or minus one and form the radicand one^2 - y^2.
    assign x_in = i_s_axis_tdata[15:0];
    assign y_in = i_s_axis_tdata[31:16];
    assign z_in = i_s_axis_tdata[47:32];

    always_comb begin
        y_sat = y_in;
        if (32'(y_in) > (32'sd1 <<< CFB)) begin
            y_sat = COORD_W'(32'sd1 <<< CFB);
        end
        if (32'(y_in) < -(32'sd1 <<< CFB)) begin
            y_sat = COORD_W'(-(32'sd1 <<< CFB));
        end
        y_sq = 32'(y_sat) * 32'(y_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (ce) begin
            r_p_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_p_n    <= (SQ_IN_W'(1) << (2 * CFB)) - SQ_IN_W'($unsigned(y_sq));
            r_p_side <= {z_in, y_sat, x_in};
        end
    end

    suv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_p_vld),
        .i_n     (r_p_n),
        .i_side  (r_p_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Scale both vectors for the CORDIC datapath.
    assign sq_x  = sq_side[15:0];
    assign sq_y  = sq_side[31:16];
    assign sq_z  = sq_side[47:32];
    assign phi_a = CW'(sq_x) <<< SC_XZ;
    assign phi_b = CW'(sq_z) <<< SC_XZ;
    assign th_a  = CW'($signed({1'b0, sq_root})) <<< SC_Y;
    assign th_b  = CW'(sq_y) <<< SC_Y;

    suv_cordic u_cordic_phi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (sq_vld),
        .i_a     (phi_a),
        .i_b     (phi_b),
        .o_valid (phi_vld),
        .o_angle (phi)
    );

    suv_cordic u_cordic_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (sq_vld),
        .i_a     (th_a),
        .i_b     (th_b),
        .o_valid (th_vld),
        .o_angle (theta)
    );

    // Offset, clamp and round into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_out_vld <= phi_vld && th_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_u <= to_out((AW+2)'(phi) + (AW+2)'(64'sd1 <<< 31));
            r_v <= to_out((AW+2)'(64'sd1 <<< 31) - ((AW+2)'(theta) <<< 1));
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_v, r_u};

endmodule

// ----- design/suv_sqrt.sv -----
module suv_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ce,
    input  logic                         i_valid,
    input  logic [suv_pkg::SQ_IN_W-1:0]  i_n,
    input  logic [suv_pkg::SIDE_W-1:0]   i_side,
    output logic                         o_valid,
    output logic [suv_pkg::SQ_K-1:0]     o_root,
    output logic [suv_pkg::SIDE_W-1:0]   o_side
);
    import suv_pkg::*;

    // Stage s holds the remainder and root after deciding root bit SQ_K-s.
    logic [SQ_TW-1:0]  r_rem  [1:SQ_K];
    logic [SQ_K-1:0]   r_q    [1:SQ_K];
    logic [SIDE_W-1:0] r_side [1:SQ_K];
    logic              r_vld  [1:SQ_K];
    logic [SQ_TW-1:0]  n_rem  [1:SQ_K];
    logic [SQ_K-1:0]   n_q    [1:SQ_K];

    // One restoring step: try setting root bit b.
    function automatic logic [SQ_TW+SQ_K-1:0] root_step(input logic [SQ_TW-1:0] rem,
                                                        input logic [SQ_K-1:0]  q,
                                                        input int               b);
        logic [SQ_TW-1:0] trial;
        logic [SQ_TW-1:0] rem_o;
        logic [SQ_K-1:0]  q_o;
        trial = (SQ_TW'(q) << (b + 1)) + (SQ_TW'(1) << (2 * b));
        rem_o = rem;
        q_o   = q;
        if (rem >= trial) begin
            rem_o = rem - trial;
            q_o   = q | (SQ_K'(1) << b);
        end
        return {rem_o, q_o};
    endfunction

    // The first stage works on the input, the others on the stage before.
    always_comb begin
        {n_rem[1], n_q[1]} = root_step(SQ_TW'(i_n), '0, SQ_K - 1);
        for (int s = 2; s <= SQ_K; s++) begin
            {n_rem[s], n_q[s]} = root_step(r_rem[s-1], r_q[s-1], SQ_K - s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= SQ_K; s++) r_vld[s] <= 1'b0;
        end else if (i_ce) begin
            r_vld[1] <= i_valid;
            for (int s = 2; s <= SQ_K; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_side[1] <= i_side;
            for (int s = 1; s <= SQ_K; s++) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
            end
            for (int s = 2; s <= SQ_K; s++) r_side[s] <= r_side[s-1];
        end
    end

    assign o_valid = r_vld[SQ_K];
    assign o_root  = r_q[SQ_K];
    assign o_side  = r_side[SQ_K];

endmodule

// ----- design/suv_cordic.sv -----
module suv_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_valid,
    input  logic signed [suv_pkg::CW-1:0] i_a,
    input  logic signed [suv_pkg::CW-1:0] i_b,
    output logic                          o_valid,
    output logic signed [suv_pkg::AW-1:0] o_angle
);
    import suv_pkg::*;

    // Index 0 is the quarter-turn pre-rotation, index i+1 holds iteration i.
    logic signed [CW-1:0] r_a    [0:NIT];
    logic signed [CW-1:0] r_b    [0:NIT];
    logic signed [AW-1:0] r_acc  [0:NIT];
    logic                 r_zero [0:NIT];
    logic                 r_vld  [0:NIT];
    logic signed [CW-1:0] n_a    [0:NIT];
    logic signed [CW-1:0] n_b    [0:NIT];
    logic signed [AW-1:0] n_acc  [0:NIT];

    always_comb begin
        // Pre-rotation moves a vector in the left half plane to the right.
        n_a[0]   = i_a;
        n_b[0]   = i_b;
        n_acc[0] = '0;
        if (i_a < 0) begin
            if (i_b >= 0) begin
                n_a[0]   = i_b;
                n_b[0]   = -i_a;
                n_acc[0] = AW'(64'sd1 <<< 30);
            end else begin
                n_a[0]   = -i_b;
                n_b[0]   = i_a;
                n_acc[0] = -AW'(64'sd1 <<< 30);
            end
        end
        // Vectoring iterations drive b toward zero.
        for (int i = 0; i < NIT; i++) begin
            if (r_b[i] > 0) begin
                n_a[i+1]   = r_a[i] + (r_b[i] >>> i);
                n_b[i+1]   = r_b[i] - (r_a[i] >>> i);
                n_acc[i+1] = r_acc[i] + turn_tab(5'(i));
            end else begin
                n_a[i+1]   = r_a[i] - (r_b[i] >>> i);
                n_b[i+1]   = r_b[i] + (r_a[i] >>> i);
                n_acc[i+1] = r_acc[i] - turn_tab(5'(i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NIT; i++) r_vld[i] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i <= NIT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_zero[0] <= (i_a == 0) && (i_b == 0);
            for (int i = 0; i <= NIT; i++) begin
                r_a[i]   <= n_a[i];
                r_b[i]   <= n_b[i];
                r_acc[i] <= n_acc[i];
            end
            for (int i = 1; i <= NIT; i++) r_zero[i] <= r_zero[i-1];
        end
    end

    // The origin has angle zero.
    assign o_valid = r_vld[NIT];
    assign o_angle = r_zero[NIT] ? '0 : r_acc[NIT];

endmodule
